[design/pse_pkg.sv]
// Shared constants and types for the postfix stack evaluator.
`timescale 1ns / 1ps

package pse_pkg;

  // Default sizes of the operand stack.
  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned DATA_WIDTH_DEF  = 32;

  // Width of the result value port.
  localparam int unsigned VALUE_W = 32;

  // Character codes that the evaluator recognizes.
  localparam logic [7:0] SYM_END      = 8'h00;
  localparam logic [7:0] SYM_DIGIT_LO = 8'h30;
  localparam logic [7:0] SYM_DIGIT_HI = 8'h39;
  localparam logic [7:0] SYM_ADD      = 8'h2B;
  localparam logic [7:0] SYM_SUB      = 8'h2D;
  localparam logic [7:0] SYM_MUL      = 8'h2A;
  localparam logic [7:0] SYM_DIV      = 8'h2F;

  // Status codes reported with each result item.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIV_ZERO  = 2'd3
  } status_e;

  // Operations of the arithmetic unit.
  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_e;

  // Request from the stack controller to the arithmetic unit.
  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

endpackage

[design/pse_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module pse_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/pse_alu.sv]
// Multi-cycle arithmetic unit: add, subtract, split multiply and radix-2 divide.
`timescale 1ns / 1ps

module pse_alu import pse_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  alu_req_t              req_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] result_o
);

  localparam int unsigned HALF_W = (DATA_WIDTH + 1) / 2;
  localparam int unsigned HI_W   = DATA_WIDTH - HALF_W;
  localparam int unsigned CNT_W  = $clog2(DATA_WIDTH);

  // Multiply steps: low by low, high by low, low by high, final sum.
  localparam logic [CNT_W-1:0] MUL_STEP_LL  = CNT_W'(0);
  localparam logic [CNT_W-1:0] MUL_STEP_HL  = CNT_W'(1);
  localparam logic [CNT_W-1:0] MUL_STEP_LH  = CNT_W'(2);
  localparam logic [CNT_W-1:0] MUL_STEP_SUM = CNT_W'(3);
  localparam logic [CNT_W-1:0] DIV_LAST     = CNT_W'(DATA_WIDTH - 1);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_FIX  = 4'b1000
  } alu_state_e;

  alu_state_e              state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    done_q, done_d;
  logic [DATA_WIDTH-1:0]   a_q, a_d;
  logic [DATA_WIDTH-1:0]   b_q, b_d;
  logic [DATA_WIDTH-1:0]   acc_q, acc_d;
  logic [DATA_WIDTH-1:0]   res_q, res_d;
  logic [2*HALF_W-1:0]     prod_q, prod_d;
  logic                    neg_q, neg_d;

  logic [HALF_W-1:0]       mul_x;
  logic [HALF_W-1:0]       mul_y;
  logic [2*HALF_W-1:0]     mul_p;
  logic [DATA_WIDTH-1:0]   prod_sh;
  logic [DATA_WIDTH:0]     rem_sh;
  logic [DATA_WIDTH:0]     rem_diff;

  // Operand halves for the shared multiplier, one partial product per step.
  always_comb begin
    if (cnt_q == MUL_STEP_LL) begin
      mul_x = a_q[HALF_W-1:0];
      mul_y = b_q[HALF_W-1:0];
    end else if (cnt_q == MUL_STEP_HL) begin
      mul_x = HALF_W'(a_q[DATA_WIDTH-1:HALF_W]);
      mul_y = b_q[HALF_W-1:0];
    end else begin
      mul_x = a_q[HALF_W-1:0];
      mul_y = HALF_W'(b_q[DATA_WIDTH-1:HALF_W]);
    end
  end

  assign mul_p   = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};
  assign prod_sh = {prod_q[HI_W-1:0], {HALF_W{1'b0}}};

  // One restoring division step: shift in the next dividend bit and try a subtract.
  assign rem_sh   = {acc_q, a_q[DATA_WIDTH-1]};
  assign rem_diff = rem_sh - {1'b0, b_q};

  // Sequencer for all operations.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    res_d   = res_q;
    prod_d  = prod_q;
    neg_d   = neg_q;

    unique case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          unique case (req_i.op)
            ALU_ADD: begin
              res_d  = left_i + right_i;
              done_d = 1'b1;
            end
            ALU_SUB: begin
              res_d  = left_i - right_i;
              done_d = 1'b1;
            end
            ALU_MUL: begin
              a_d     = left_i;
              b_d     = right_i;
              cnt_d   = '0;
              state_d = A_MUL;
            end
            ALU_DIV: begin
              a_d     = left_i[DATA_WIDTH-1] ? ('0 - left_i) : left_i;
              b_d     = right_i[DATA_WIDTH-1] ? ('0 - right_i) : right_i;
              neg_d   = left_i[DATA_WIDTH-1] ^ right_i[DATA_WIDTH-1];
              acc_d   = '0;
              cnt_d   = '0;
              state_d = A_DIV;
            end
            default: state_d = A_IDLE;
          endcase
        end
      end

      A_MUL: begin
        prod_d = mul_p;
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q == MUL_STEP_HL) begin
          acc_d = prod_q[DATA_WIDTH-1:0];
        end else if (cnt_q == MUL_STEP_LH) begin
          acc_d = acc_q + prod_sh;
        end else if (cnt_q == MUL_STEP_SUM) begin
          res_d   = acc_q + prod_sh;
          done_d  = 1'b1;
          state_d = A_IDLE;
        end
      end

      A_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (!rem_diff[DATA_WIDTH]) begin
          acc_d = rem_diff[DATA_WIDTH-1:0];
          a_d   = {a_q[DATA_WIDTH-2:0], 1'b1};
        end else begin
          acc_d = rem_sh[DATA_WIDTH-1:0];
          a_d   = {a_q[DATA_WIDTH-2:0], 1'b0};
        end
        if (cnt_q == DIV_LAST) begin
          state_d = A_FIX;
        end
      end

      A_FIX: begin
        res_d   = neg_q ? ('0 - a_q) : a_q;
        done_d  = 1'b1;
        state_d = A_IDLE;
      end

      default: state_d = A_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

[design/postfix_stack_evaluator.sv]
// Top level of the postfix stack evaluator: stack control, stack RAM and arithmetic unit.
//
// Usage: each input item on in_valid_i / in_ready_o is one ASCII character on symbol_i.
// A digit pushes its value, + - * / pop two entries and push the result, any other
// nonzero character pops two and pushes zero, and a zero byte ends the expression.
// The end item produces one result item on out_valid_o / out_ready_i carrying the
// top of stack in value_o (zero on an error) and the first error of the expression
// in status_o; the stack and the error are then cleared.
// Digits, unknown characters, error cases and the end byte need no further state.
// An arithmetic operator reads the entry below the cached top from the stack RAM
// and then runs the arithmetic unit: + and - are computed directly, * takes four
// shared half-width multiplier steps, / one quotient bit per cycle plus a sign fix.
// The result appears in the output register the cycle after the end item is taken.
// Reset empties the stack and clears the error; the RAM needs no clearing pass.
// While a result waits for out_ready_i, characters other than the end byte are
// still accepted; a further end byte waits until the output register is free.
`timescale 1ns / 1ps

module postfix_stack_evaluator import pse_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                symbol_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [VALUE_W-1:0] value_o,
  output logic [1:0]                status_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EXEC = 3'b100
  } ctrl_state_e;

  ctrl_state_e           state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [DATA_WIDTH-1:0] top_q, top_d;
  status_e               err_q, err_d;
  alu_op_e               op_q, op_d;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]    value_q, value_d;
  status_e               status_q, status_d;

  logic                  in_fire;
  logic                  is_end;
  logic                  is_digit;
  logic                  is_arith;
  alu_op_e               arith_op;
  status_e               end_status;
  logic [CW-1:0]         count_m1;
  logic [CW-1:0]         count_m2;

  logic                  ram_we;
  logic                  ram_re;
  logic [DATA_WIDTH-1:0] ram_rdata;

  alu_req_t              alu_req;
  logic                  alu_done;
  logic [DATA_WIDTH-1:0] alu_res;

  // Input handshake: only an end byte needs the output register to be free.
  assign is_end     = (symbol_i == SYM_END);
  assign in_ready_o = (state_q == S_IDLE) && (!is_end || !out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_digit = (symbol_i >= SYM_DIGIT_LO) && (symbol_i <= SYM_DIGIT_HI);
  assign count_m1 = count_q - CW'(1);
  assign count_m2 = count_q - CW'(2);

  // Operator decode.
  always_comb begin
    is_arith = 1'b1;
    arith_op = ALU_ADD;
    unique case (symbol_i)
      SYM_ADD: arith_op = ALU_ADD;
      SYM_SUB: arith_op = ALU_SUB;
      SYM_MUL: arith_op = ALU_MUL;
      SYM_DIV: arith_op = ALU_DIV;
      default: is_arith = 1'b0;
    endcase
  end

  // Status of the expression if it ends now.
  always_comb begin
    if (err_q != ST_OK) begin
      end_status = err_q;
    end else if (count_q == '0) begin
      end_status = ST_UNDERFLOW;
    end else begin
      end_status = ST_OK;
    end
  end

  // Stack controller. The top entry lives in top_q; the RAM holds the entries below it,
  // so a push writes the old top and an operator reads only the second entry.
  // A push and the read of an operator never fall in the same cycle, so no forwarding
  // is needed beyond the cached top.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    top_d       = top_q;
    err_d       = err_q;
    op_d        = op_q;
    out_valid_d = out_valid_q && !out_ready_i;
    value_d     = value_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    alu_req     = '{start: 1'b0, op: ALU_ADD};

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (is_end) begin
            out_valid_d = 1'b1;
            status_d    = end_status;
            value_d     = (end_status == ST_OK) ? VALUE_W'($signed(top_q)) : '0;
            count_d     = '0;
            err_d       = ST_OK;
          end else if (is_digit) begin
            if (count_q == CW'(STACK_DEPTH)) begin
              if (err_q == ST_OK) begin
                err_d = ST_OVERFLOW;
              end
            end else begin
              ram_we  = (count_q != '0);
              top_d   = DATA_WIDTH'(symbol_i - SYM_DIGIT_LO);
              count_d = count_q + CW'(1);
            end
          end else if (count_q < CW'(2)) begin
            // Operator underflow: the stack collapses to a single zero.
            if (err_q == ST_OK) begin
              err_d = ST_UNDERFLOW;
            end
            top_d   = '0;
            count_d = CW'(1);
          end else if (!is_arith || ((arith_op == ALU_DIV) && (top_q == '0))) begin
            // Unknown character or divide by zero: pop two, push zero.
            if (is_arith && (err_q == ST_OK)) begin
              err_d = ST_DIV_ZERO;
            end
            top_d   = '0;
            count_d = count_m1;
          end else begin
            ram_re  = 1'b1;
            op_d    = arith_op;
            state_d = S_READ;
          end
        end
      end

      S_READ: begin
        alu_req = '{start: 1'b1, op: op_q};
        state_d = S_EXEC;
      end

      S_EXEC: begin
        if (alu_done) begin
          top_d   = alu_res;
          count_d = count_m1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    op_q     <= op_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  // Entries below the top of stack.
  pse_ram #(
    .WIDTH  (DATA_WIDTH),
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (AW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_m1[AW-1:0]),
    .wdata_i (top_q),
    .re_i    (ram_re),
    .raddr_i (count_m2[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  pse_alu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .left_i   (ram_rdata),
    .right_i  (top_q),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  // The fill count never passes the stack depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count exceeds depth");

  // An operator only reaches the RAM read with two entries on the stack.
  a_read_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (count_q >= CW'(2)))
    else $error("operator read with fewer than two entries");

  // The arithmetic unit only finishes while the controller waits for it.
  a_done_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> (state_q == S_EXEC))
    else $error("arithmetic result arrived outside execute state");

  // A faulty expression always reports a zero value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != ST_OK)) |-> (value_q == '0))
    else $error("nonzero value reported with an error status");

  // An end byte empties the stack, clears the error and presents a result.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_end) |=> ((count_q == '0) && (err_q == ST_OK) && out_valid_q))
    else $error("end of expression did not clear the stack");
`endif

endmodule
